### design/bss_pkg.sv
// Shared types and constants of the barcode scanline sampler.
package bss_pkg;

   // Fixed field widths of the result word
   localparam int WIDTH_W = 13;
   localparam int INDEX_W = 7;
   localparam int START_W = 12;

   // Output queue geometry
   localparam int OUTQ_DEPTH = 4;
   localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
   localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

   // Result kinds
   typedef enum logic [1:0] {
      KIND_BIT   = 2'd0,
      KIND_NONE  = 2'd1,
      KIND_SHORT = 2'd2
   } kind_type;

   // One result word
   typedef struct packed {
      kind_type             kind;
      logic                 bit_value;
      logic [INDEX_W-1:0]   bit_index;
      logic [WIDTH_W-1:0]   module_width;
      logic [START_W-1:0]   start_pos;
      logic                 last;
   } result_type;

   // Up to two results produced by one pixel, always packed from slot zero
   typedef struct packed {
      logic       res0_valid;
      result_type res0;
      logic       res1_valid;
      result_type res1;
   } dec_out_type;

   // Output queue status towards the top level
   typedef struct packed {
      logic [OUTQ_CNT_W-1:0] level;
      logic                  has_room;
   } outq_status_type;

endpackage

### design/bss_decode.sv
// Per-row scanline decoder: finds the first bar, measures the module and samples the row.
module bss_decode #(
   parameter int MAX_ROW      = 4096,
   parameter int SAMPLE_COUNT = 67
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic                          pixel,
   input  logic [bss_pkg::WIDTH_W-1:0]   eff_width,
   output bss_pkg::dec_out_type          dec_out
);
   import bss_pkg::*;

   // Largest effective row width that the 13-bit register can select
   localparam int EFF_MAX = (MAX_ROW < 8191) ? MAX_ROW : 8191;
   localparam int POS_W   = $clog2(EFF_MAX);
   localparam int CMP_W   = WIDTH_W + 1;
   localparam logic FIN_AT_ZERO = (SAMPLE_COUNT <= 1);
   localparam logic FIN_AT_ONE  = (SAMPLE_COUNT <= 2);
   localparam logic [WIDTH_W-1:0] RUN_MAX = {WIDTH_W{1'b1}};

   typedef enum logic [1:0] {
      PH_SEEK,
      PH_RUN,
      PH_SAMPLE,
      PH_DONE
   } phase_type;

   phase_type            phase_ff, phase_in;
   logic [POS_W-1:0]     position_ff, position_in;
   logic [POS_W-1:0]     first_dark_ff, first_dark_in;
   logic [WIDTH_W-1:0]   run_length_ff, run_length_in;
   logic [WIDTH_W-1:0]   countdown_ff, countdown_in;
   logic [INDEX_W-1:0]   index_ff, index_in;

   logic [CMP_W-1:0]     pos_ext;
   logic [CMP_W-1:0]     width_ext;
   logic                 row_end;
   logic                 near_end;
   logic                 sample_fin;
   logic [WIDTH_W-1:0]   run_inc;
   logic [INDEX_W-1:0]   index_next;
   logic [START_W-1:0]   start_out;

   function automatic result_type make_result(
      input kind_type           kind,
      input logic               bit_value,
      input logic [INDEX_W-1:0] bit_index,
      input logic [WIDTH_W-1:0] module_width,
      input logic [START_W-1:0] start_pos,
      input logic               last
   );
      result_type r;
      r.kind         = kind;
      r.bit_value    = bit_value;
      r.bit_index    = bit_index;
      r.module_width = module_width;
      r.start_pos    = start_pos;
      r.last         = last;
      return r;
   endfunction

   // Row position tests against the effective width
   assign pos_ext    = CMP_W'(position_ff);
   assign width_ext  = CMP_W'(eff_width);
   assign row_end    = (pos_ext + CMP_W'(1)) >= width_ext;
   assign near_end   = (pos_ext + CMP_W'(3)) >= width_ext;
   assign run_inc    = (run_length_ff < RUN_MAX) ? run_length_ff + WIDTH_W'(1) : run_length_ff;
   assign index_next = index_ff + INDEX_W'(1);
   assign sample_fin = ({1'b0, index_ff} + (INDEX_W + 1)'(1)) >= (INDEX_W + 1)'(SAMPLE_COUNT);
   assign start_out  = START_W'(first_dark_ff);

   // Next state and the results of the current pixel
   always_comb begin
      phase_in      = phase_ff;
      position_in   = position_ff;
      first_dark_in = first_dark_ff;
      run_length_in = run_length_ff;
      countdown_in  = countdown_ff;
      index_in      = index_ff;
      dec_out       = '0;

      case (phase_ff)
         PH_SEEK: begin
            if (pixel) begin
               first_dark_in = position_ff;
               if (near_end) begin
                  dec_out.res0_valid = 1'b1;
                  dec_out.res0 = make_result(KIND_NONE, 1'b0, '0, '0,
                                             START_W'(position_ff), 1'b1);
                  phase_in = PH_DONE;
               end else begin
                  dec_out.res0_valid = 1'b1;
                  dec_out.res0 = make_result(KIND_BIT, 1'b1, '0, '0,
                                             START_W'(position_ff), FIN_AT_ZERO);
                  run_length_in = WIDTH_W'(1);
                  phase_in = FIN_AT_ZERO ? PH_DONE : PH_RUN;
               end
            end else if (row_end) begin
               dec_out.res0_valid = 1'b1;
               dec_out.res0 = make_result(KIND_NONE, 1'b0, '0, '0, '0, 1'b1);
               phase_in = PH_DONE;
            end
         end
         PH_RUN: begin
            if (pixel) begin
               run_length_in = run_inc;
               if (row_end) begin
                  // The bar runs to the row end, so sample one is missing
                  dec_out.res0_valid = 1'b1;
                  dec_out.res0 = make_result(KIND_SHORT, 1'b0, INDEX_W'(1), run_inc,
                                             start_out, 1'b1);
                  phase_in = PH_DONE;
               end
            end else begin
               dec_out.res0_valid = 1'b1;
               dec_out.res0 = make_result(KIND_BIT, 1'b0, INDEX_W'(1), run_length_ff,
                                          start_out, FIN_AT_ONE);
               index_in = INDEX_W'(2);
               if (FIN_AT_ONE) begin
                  phase_in = PH_DONE;
               end else begin
                  countdown_in = run_length_ff - WIDTH_W'(1);
                  phase_in = PH_SAMPLE;
                  if (row_end) begin
                     dec_out.res1_valid = 1'b1;
                     dec_out.res1 = make_result(KIND_SHORT, 1'b0, INDEX_W'(2),
                                                run_length_ff, start_out, 1'b1);
                     phase_in = PH_DONE;
                  end
               end
            end
         end
         PH_SAMPLE: begin
            if (countdown_ff == '0) begin
               dec_out.res0_valid = 1'b1;
               dec_out.res0 = make_result(KIND_BIT, pixel, index_ff, run_length_ff,
                                          start_out, sample_fin);
               index_in = index_next;
               if (sample_fin) begin
                  phase_in = PH_DONE;
               end else begin
                  countdown_in = run_length_ff - WIDTH_W'(1);
                  if (row_end) begin
                     dec_out.res1_valid = 1'b1;
                     dec_out.res1 = make_result(KIND_SHORT, 1'b0, index_next,
                                                run_length_ff, start_out, 1'b1);
                     phase_in = PH_DONE;
                  end
               end
            end else begin
               countdown_in = countdown_ff - WIDTH_W'(1);
               if (row_end) begin
                  dec_out.res0_valid = 1'b1;
                  dec_out.res0 = make_result(KIND_SHORT, 1'b0, index_ff, run_length_ff,
                                             start_out, 1'b1);
                  phase_in = PH_DONE;
               end
            end
         end
         default: begin
         end
      endcase

      // The last pixel of a row returns the decoder to its start state
      if (row_end) begin
         phase_in      = PH_SEEK;
         position_in   = '0;
         first_dark_in = '0;
         run_length_in = '0;
         countdown_in  = '0;
         index_in      = '0;
      end else begin
         position_in = position_ff + POS_W'(1);
      end

      if (!accept) begin
         dec_out = '0;
      end
   end

   // Row state, advanced once per accepted pixel
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_SEEK;
         position_ff   <= '0;
         first_dark_ff <= '0;
         run_length_ff <= '0;
         countdown_ff  <= '0;
         index_ff      <= '0;
      end else if (accept) begin
         phase_ff      <= phase_in;
         position_ff   <= position_in;
         first_dark_ff <= first_dark_in;
         run_length_ff <= run_length_in;
         countdown_ff  <= countdown_in;
         index_ff      <= index_in;
      end
   end

endmodule

### design/bss_outq.sv
// Small result queue that takes up to two words per cycle and hands out one.
module bss_outq (
   input  logic                      clock,
   input  logic                      reset,
   input  bss_pkg::dec_out_type      push,
   input  logic                      pop,
   output logic                      head_valid,
   output bss_pkg::result_type       head,
   output bss_pkg::outq_status_type  status
);
   import bss_pkg::*;

   result_type               entry_ff [OUTQ_DEPTH];
   logic [OUTQ_PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [OUTQ_PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [OUTQ_CNT_W-1:0]    level_ff, level_in;
   logic [1:0]               push_count;
   logic                     do_pop;

   // Occupancy bookkeeping
   assign push_count = {1'b0, push.res0_valid} + {1'b0, push.res1_valid};
   assign do_pop     = pop && (level_ff != '0);
   assign wr_ptr_in  = wr_ptr_ff + OUTQ_PTR_W'(push_count);
   assign rd_ptr_in  = rd_ptr_ff + OUTQ_PTR_W'(do_pop);
   assign level_in   = level_ff + OUTQ_CNT_W'(push_count) - OUTQ_CNT_W'(do_pop);

   assign head_valid      = (level_ff != '0);
   assign head            = entry_ff[rd_ptr_ff];
   assign status.level    = level_ff;
   assign status.has_room = (level_ff <= OUTQ_CNT_W'(OUTQ_DEPTH - 2));

   // Pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   // Result storage, written in arrival order
   always_ff @(posedge clock) begin
      if (push.res0_valid) begin
         entry_ff[wr_ptr_ff] <= push.res0;
      end
      if (push.res1_valid) begin
         entry_ff[wr_ptr_ff + OUTQ_PTR_W'(1)] <= push.res1;
      end
   end

endmodule

### design/barcode_scanline_sampler.sv
// Top level of the barcode scanline sampler: width register, decoder and result queue.
//
// The block takes one pixel word per cycle unless stalled, and each pixel is handled
// in the cycle that accepts it by the row decoder, whose results go straight into a
// four-word queue in front of the result port; a result word is on rsp_* at the
// earliest in the cycle after its pixel, or later while older words wait. A pixel gives
// at most two result words (the second only on a row's last pixel), and req_stall
// rises while fewer than two queue places are free. With an unstalled result port one
// word leaves per cycle, so the input stalls only when the rows make words faster than
// that, as rows of a few pixels that end on a sample and a short-row word can do. The
// row width written on the csr port is clamped to 1 .. MAX_ROW and applies from the
// next pixel on; the decoder starts a new row after each row's last pixel.
module barcode_scanline_sampler #(
   parameter int MAX_ROW      = 4096,
   parameter int SAMPLE_COUNT = 67
) (
   input  logic                          clock,
   input  logic                          reset,
   // Pixel input
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_pixel,
   // Result output
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [1:0]                    rsp_kind,
   output logic                          rsp_bit_value,
   output logic [bss_pkg::INDEX_W-1:0]   rsp_bit_index,
   output logic [bss_pkg::WIDTH_W-1:0]   rsp_module_width,
   output logic [bss_pkg::START_W-1:0]   rsp_start_pos,
   output logic                          rsp_last,
   // Row width register
   input  logic                          csr_wr_en,
   input  logic [bss_pkg::WIDTH_W-1:0]   csr_wr_data
);
   import bss_pkg::*;

   localparam int RESET_WIDTH = (MAX_ROW < 4096) ? MAX_ROW : 4096;

   logic [WIDTH_W-1:0]  width_ff, width_in;
   logic                accept;
   logic                pop;
   dec_out_type         dec_out;
   result_type          head;
   outq_status_type     outq_status;

   // Clamp the written row width into the usable range
   always_comb begin
      if (csr_wr_data == '0) begin
         width_in = WIDTH_W'(1);
      end else if (int'(csr_wr_data) > MAX_ROW) begin
         width_in = WIDTH_W'(MAX_ROW);
      end else begin
         width_in = csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= WIDTH_W'(RESET_WIDTH);
      end else if (csr_wr_en) begin
         width_ff <= width_in;
      end
   end

   // Handshakes
   assign req_stall = !outq_status.has_room;
   assign accept    = req_valid && !req_stall;
   assign pop       = rsp_valid && !rsp_stall;

   bss_decode #(
      .MAX_ROW      (MAX_ROW),
      .SAMPLE_COUNT (SAMPLE_COUNT)
   ) u_decode (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .pixel     (req_pixel),
      .eff_width (width_ff),
      .dec_out   (dec_out)
   );

   bss_outq u_outq (
      .clock      (clock),
      .reset      (reset),
      .push       (dec_out),
      .pop        (pop),
      .head_valid (rsp_valid),
      .head       (head),
      .status     (outq_status)
   );

   // Result word onto the ports
   assign rsp_kind         = head.kind;
   assign rsp_bit_value    = head.bit_value;
   assign rsp_bit_index    = head.bit_index;
   assign rsp_module_width = head.module_width;
   assign rsp_start_pos    = head.start_pos;
   assign rsp_last         = head.last;

   // The queue never holds more words than it has places
   assert property (@(posedge clock) disable iff (reset)
      outq_status.level <= OUTQ_CNT_W'(OUTQ_DEPTH))
      else $error("result queue overfilled");

   // A second result in one cycle is always the closing short-row error after a first one
   assert property (@(posedge clock) disable iff (reset)
      dec_out.res1_valid |-> dec_out.res0_valid && dec_out.res1.last &&
                             dec_out.res1.kind == KIND_SHORT)
      else $error("second result out of order");

   // A result only appears after the decoder produced one
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(dec_out.res0_valid))
      else $error("result word appeared without a decoded pixel");

endmodule

### tb/barcode_scanline_sampler_tb.sv
// Self-checking testbench for the barcode scanline sampler, with its own row decoder for prediction.
module barcode_scanline_sampler_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bss_pkg::*;

   localparam int MAX_ROW      = 4096;
   localparam int SAMPLES      = 67;
   localparam int RANDOM_ITEMS = 1300;

   typedef enum {SCAN_SEEK, SCAN_RUN, SCAN_SAMPLE, SCAN_DONE} scan_phase_type;
   typedef enum {ROW_CLEAN, ROW_DAMAGED, ROW_NOISE, ROW_BLANK} row_style_type;

   logic clock;
   logic reset = 1'b1;

   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic                 req_pixel = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [1:0]           rsp_kind;
   logic                 rsp_bit_value;
   logic [INDEX_W-1:0]   rsp_bit_index;
   logic [WIDTH_W-1:0]   rsp_module_width;
   logic [START_W-1:0]   rsp_start_pos;
   logic                 rsp_last;
   logic                 csr_wr_en = 1'b0;
   logic [WIDTH_W-1:0]   csr_wr_data = '0;

   barcode_scanline_sampler #(
      .MAX_ROW      (MAX_ROW),
      .SAMPLE_COUNT (SAMPLES)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_pixel        (req_pixel),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_bit_value    (rsp_bit_value),
      .rsp_bit_index    (rsp_bit_index),
      .rsp_module_width (rsp_module_width),
      .rsp_start_pos    (rsp_start_pos),
      .rsp_last         (rsp_last),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   // Pixels waiting to be sent and result words waiting to be seen.
   bit         pixel_queue[$];
   result_type expected_words[$];

   // Decoder state as predicted by the testbench.
   logic [WIDTH_W-1:0] row_width_cfg = 13'd4096;
   scan_phase_type     scan_phase = SCAN_SEEK;
   int                 scan_pos, dark_start, run_len, countdown, sample_no;

   int cycle_no, send_gap, stall_left, items_queued, settings_used;
   int pixels_taken, words_checked, mismatch_count;
   int decodes_done, rows_no_code, rows_cut;
   bit hold_used;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_no <= cycle_no + 1;
   end

   // Gap length for either side: none during calm windows, else mostly short.
   function automatic int gap_length();
      int r;
      if (cycle_no[8:7] == 2'b00) return 0;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 94) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic push_word(input kind_type k, input logic b, input int idx, input int mw,
                            input int start, input logic fin);
      result_type w;
      w.kind         = k;
      w.bit_value    = b;
      w.bit_index    = INDEX_W'(idx);
      w.module_width = WIDTH_W'(mw);
      w.start_pos    = START_W'(start);
      w.last         = fin;
      expected_words.push_back(w);
      if (fin) begin
         case (k)
            KIND_BIT:  decodes_done++;
            KIND_NONE: rows_no_code++;
            default:   rows_cut++;
         endcase
      end
   endtask

   // Advance the predicted decoder by one accepted pixel.
   task automatic decode_pixel(input logic pix);
      int eff;
      int p;
      bit row_end;
      bit fin;
      eff = row_width_cfg;
      if (eff < 1) eff = 1;
      if (eff > MAX_ROW) eff = MAX_ROW;
      p = scan_pos;
      row_end = (p + 1 >= eff);
      case (scan_phase)
         SCAN_SEEK: begin
            if (pix) begin
               dark_start = p;
               if (p + 3 >= eff) begin
                  push_word(KIND_NONE, 1'b0, 0, 0, p, 1'b1);
                  scan_phase = SCAN_DONE;
               end else begin
                  fin = (SAMPLES <= 1);
                  push_word(KIND_BIT, 1'b1, 0, 0, p, fin);
                  run_len = 1;
                  scan_phase = fin ? SCAN_DONE : SCAN_RUN;
               end
            end else if (row_end) begin
               push_word(KIND_NONE, 1'b0, 0, 0, 0, 1'b1);
               scan_phase = SCAN_DONE;
            end
         end
         SCAN_RUN: begin
            if (pix) begin
               if (run_len < 8191) run_len++;
               if (row_end) begin
                  push_word(KIND_SHORT, 1'b0, 1, run_len, dark_start, 1'b1);
                  scan_phase = SCAN_DONE;
               end
            end else begin
               // The first white pixel after the run is sample one.
               fin = (2 >= SAMPLES);
               push_word(KIND_BIT, 1'b0, 1, run_len, dark_start, fin);
               sample_no = 2;
               if (fin) begin
                  scan_phase = SCAN_DONE;
               end else begin
                  countdown = run_len - 1;
                  scan_phase = SCAN_SAMPLE;
                  if (row_end) begin
                     push_word(KIND_SHORT, 1'b0, sample_no, run_len, dark_start, 1'b1);
                     scan_phase = SCAN_DONE;
                  end
               end
            end
         end
         SCAN_SAMPLE: begin
            if (countdown == 0) begin
               fin = (sample_no + 1 >= SAMPLES);
               push_word(KIND_BIT, pix, sample_no, run_len, dark_start, fin);
               sample_no++;
               if (fin) scan_phase = SCAN_DONE;
               else countdown = run_len - 1;
            end else begin
               countdown--;
            end
            if (scan_phase == SCAN_SAMPLE && row_end) begin
               push_word(KIND_SHORT, 1'b0, sample_no, run_len, dark_start, 1'b1);
               scan_phase = SCAN_DONE;
            end
         end
         default: ;
      endcase
      if (row_end) begin
         scan_phase = SCAN_SEEK;
         scan_pos   = 0;
         dark_start = 0;
         run_len    = 0;
         countdown  = 0;
         sample_no  = 0;
      end else begin
         scan_pos = p + 1;
      end
   endtask

   // Pixel driver: holds a stalled word, then either pauses or takes the next pixel.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_pixel <= 1'b0;
         send_gap  <= 0;
      end else if (!req_valid || !req_stall) begin
         if (send_gap > 0) begin
            req_valid <= 1'b0;
            send_gap  <= send_gap - 1;
         end else if (pixel_queue.size() != 0) begin
            req_valid <= 1'b1;
            req_pixel <= pixel_queue.pop_front();
            send_gap  <= gap_length();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Every accepted pixel feeds the predicted decoder.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         decode_pixel(req_pixel);
         pixels_taken++;
      end
   end

   task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   // Result monitor and receiver stall, including one long hold-off under load.
   always @(posedge clock) begin
      result_type want;
      int g;
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               $display("%0t: result word with none expected, actual kind %0d index %0d",
                        $time, rsp_kind, rsp_bit_index);
               mismatch_count++;
            end else begin
               want = expected_words.pop_front();
               check_field("kind", 16'(want.kind), 16'(rsp_kind));
               check_field("bit_value", 16'(want.bit_value), 16'(rsp_bit_value));
               check_field("bit_index", 16'(want.bit_index), 16'(rsp_bit_index));
               check_field("module_width", 16'(want.module_width), 16'(rsp_module_width));
               check_field("start_pos", 16'(want.start_pos), 16'(rsp_start_pos));
               check_field("last", 16'(want.last), 16'(rsp_last));
            end
            words_checked++;
         end
         if (stall_left > 0) begin
            rsp_stall  <= 1'b1;
            stall_left <= stall_left - 1;
         end else if (!hold_used && words_checked >= 300 && pixel_queue.size() > 20) begin
            rsp_stall  <= 1'b1;
            stall_left <= 250;
            hold_used  <= 1'b1;
         end else begin
            g = gap_length();
            rsp_stall  <= (g != 0);
            stall_left <= (g > 0) ? g - 1 : 0;
         end
      end
   end

   // Wait until every pixel is taken and every predicted word has arrived.
   task automatic wait_idle();
      do @(negedge clock);
      while (pixel_queue.size() != 0 || req_valid || expected_words.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_row_width(input logic [WIDTH_W-1:0] value);
      wait_idle();
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en     <= 1'b0;
      row_width_cfg = value;
      settings_used++;
   endtask

   // Queue a fixed pattern, most significant bit first.
   task automatic queue_pattern(input logic [31:0] bits, input int count);
      for (int i = count - 1; i >= 0; i--) pixel_queue.push_back(bits[i]);
   endtask

   // Queue one row: leading white, a start run one module wide, then random modules (noise and blank rows excepted).
   task automatic queue_row(input int lead, input int mw, input row_style_type style,
                            input int count);
      bit mods[SAMPLES];
      int m;
      bit pix;
      foreach (mods[i]) mods[i] = $urandom_range(0, 1);
      mods[0] = 1'b1;
      if (SAMPLES > 1) mods[1] = 1'b0;
      for (int pos = 0; pos < count; pos++) begin
         if (style == ROW_BLANK) begin
            pix = 1'b0;
         end else if (style == ROW_NOISE) begin
            pix = ($urandom_range(0, 2) == 0);
         end else if (pos < lead) begin
            pix = 1'b0;
         end else begin
            m = (pos - lead) / mw;
            pix = (m < SAMPLES) ? mods[m] : 1'($urandom_range(0, 1));
         end
         if (style == ROW_DAMAGED && $urandom_range(0, 24) == 0) pix = ~pix;
         pixel_queue.push_back(pix);
      end
      items_queued += count;
   endtask

   function automatic row_style_type pick_style();
      int r;
      r = $urandom_range(0, 9);
      if (r < 6) return ROW_CLEAN;
      if (r < 8) return ROW_DAMAGED;
      if (r < 9) return ROW_NOISE;
      return ROW_BLANK;
   endfunction

   // Part of a row at the largest width, then a narrower width cuts it short.
   task automatic queue_wide_row(input logic [WIDTH_W-1:0] code, input int modules,
                                 input int cut_width);
      int lead, mw;
      lead = $urandom_range(0, 20);
      mw   = $urandom_range(2, 3);
      write_row_width(code);
      queue_row(lead, mw, ROW_CLEAN, lead + modules * mw);
      write_row_width(13'd4096);
      queue_row(0, 1, ROW_NOISE, 40);
      write_row_width(WIDTH_W'(cut_width));
   endtask

   initial begin
      int sel, w, lead, mw, drain;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed: a dark pixel at the reset width, then a cut to width zero, which acts as one.
      queue_pattern(32'b0001, 4);
      write_row_width(13'd0);
      // The row ends on a white pixel: sample one and a short-row word together.
      // Then single-pixel rows fail whether dark or white.
      queue_pattern(32'b010, 3);
      write_row_width(13'd4);
      // A run reaching the row end, then a dark pixel too close to the end.
      queue_pattern(32'b1111_0101, 8);
      write_row_width(13'd5);
      // Samples running past the row end.
      queue_pattern(32'b10100, 5);
      write_row_width(13'd3);
      // A row with no dark pixel.
      queue_pattern(32'b000, 3);
      items_queued = 0;

      // Random rows, mostly well formed, with one excursion to the largest widths.
      while (items_queued < RANDOM_ITEMS) begin
         if (items_queued >= RANDOM_ITEMS / 2 && items_queued < RANDOM_ITEMS / 2 + 40) begin
            queue_wide_row(13'h1FFF, 30, $urandom_range(10, 50));
            queue_wide_row(13'd4096, SAMPLES + 5, $urandom_range(10, 50));
         end
         sel = $urandom_range(0, 9);
         if (sel < 5) begin
            mw   = ($urandom_range(0, 3) == 0) ? 2 : 1;
            lead = $urandom_range(0, 6);
            w    = lead + SAMPLES * mw + $urandom_range(0, 8);
         end else if (sel < 8) begin
            w    = $urandom_range(1, 40);
            lead = $urandom_range(0, w);
            mw   = $urandom_range(1, 4);
         end else begin
            w    = $urandom_range(40, 90);
            lead = $urandom_range(0, 10);
            mw   = $urandom_range(1, 3);
         end
         write_row_width(WIDTH_W'(w));
         repeat ($urandom_range(1, 3)) queue_row(lead, mw, pick_style(), w);
      end

      // Drain, with a bound, then allow for the block's latency.
      drain = 0;
      while ((pixel_queue.size() != 0 || req_valid || expected_words.size() != 0)
             && drain < 100000) begin
         @(negedge clock);
         drain++;
      end
      repeat (10) @(negedge clock);
      if (expected_words.size() != 0) begin
         $display("%0t: %0d expected result words never arrived", $time,
                  expected_words.size());
         mismatch_count++;
      end
      $display("Covered %0d pixels over %0d row width settings; %0d result words checked.",
               pixels_taken, settings_used, words_checked);
      $display("Rows: %0d full decodes, %0d without a barcode, %0d cut short by the row end.",
               decodes_done, rows_no_code, rows_cut);
      if (mismatch_count == 0) begin
         $display("[barcode_scanline_sampler] OK");
      end else begin
         $display("[barcode_scanline_sampler] ERROR");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #2_000_000;
      $display("Timeout with %0d result words outstanding.", expected_words.size());
      $display("[barcode_scanline_sampler] ERROR");
      $finish;
   end

endmodule
